@@ rtl/core/fdc_pkg.sv @@
// shared types, codes and reset values for the frame deframer
`timescale 1ns / 1ps
`default_nettype none

package fdc_pkg;

  // register indexes on the configuration port
  localparam logic [1:0] REG_SOF_FIRST   = 2'd0;
  localparam logic [1:0] REG_SOF_SECOND  = 2'd1;
  localparam logic [1:0] REG_MAX_PAYLOAD = 2'd2;

  localparam logic [7:0]  SOF_FIRST_RST   = 8'hA5;
  localparam logic [7:0]  SOF_SECOND_RST  = 8'h5A;
  localparam logic [15:0] MAX_PAYLOAD_RST = 16'd1024;

  typedef enum logic [1:0] {
    ST_NONE    = 2'd0,
    ST_DONE    = 2'd1,
    ST_HDR_ERR = 2'd2,
    ST_CRC_ERR = 2'd3
  } status_e;

  // parser phase
  typedef enum logic [2:0] {
    PH_HUNT,
    PH_SOF,
    PH_HEADER,
    PH_PAYLOAD,
    PH_TRAILER
  } phase_e;

  typedef struct packed {
    logic [7:0]  sof_first;
    logic [7:0]  sof_second;
    logic [15:0] max_payload;
  } cfg_t;

  typedef struct packed {
    status_e     status;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic [7:0]  frame_version;
    logic [7:0]  frame_command;
    logic [15:0] frame_sequence;
    logic [15:0] frame_len;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/core/fdc_parser.sv @@
// byte-wise frame parser: marker hunt, header check, payload and trailer crc
`timescale 1ns / 1ps
`default_nettype none

module fdc_parser import fdc_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,
  input  wire logic [7:0] byte_i,
  input  wire cfg_t       cfg_i,
  output result_t         res_o
);

  localparam int HdrBytes = 10;
  localparam int WinBytes = HdrBytes - 1;

  // crc-16/ccitt-false, one byte
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
    end
    return c;
  endfunction

  // reflected crc-32, one byte
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
    end
    return c;
  endfunction

  phase_e      phase_q, phase_d;
  logic [3:0]  hdr_pos_q, hdr_pos_d;
  logic [15:0] pay_idx_q, pay_idx_d;
  logic [1:0]  lane_q, lane_d;
  logic [31:0] pcrc_q, pcrc_d;
  logic [23:0] trl_q, trl_d;
  logic [7:0]  win_q [WinBytes];
  logic [7:0]  win_d [WinBytes];

  logic [7:0]  w [HdrBytes];
  logic [15:0] len;
  logic [15:0] hcrc;
  logic        hdr_bad;
  logic [HdrBytes-2:1] hit;

  always_comb begin
    for (int j = 0; j < WinBytes; j++) begin
      w[j] = win_q[j];
    end
    w[HdrBytes-1] = byte_i;
    len = {win_q[7], win_q[6]};
    // header crc spans bytes 2..7, all held by the time the tenth byte arrives
    hcrc = 16'hFFFF;
    for (int j = 2; j < 8; j++) begin
      hcrc = crc16_byte(hcrc, win_q[j]);
    end
    hdr_bad = (len > cfg_i.max_payload) || ({byte_i, win_q[8]} != hcrc);
    for (int k = 1; k < HdrBytes - 1; k++) begin
      hit[k] = (w[k] == cfg_i.sof_first) && (w[k+1] == cfg_i.sof_second);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HUNT;
      hdr_pos_q <= '0;
      pay_idx_q <= '0;
      lane_q    <= '0;
      pcrc_q    <= '1;
    end else begin
      phase_q   <= phase_d;
      hdr_pos_q <= hdr_pos_d;
      pay_idx_q <= pay_idx_d;
      lane_q    <= lane_d;
      pcrc_q    <= pcrc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    trl_q <= trl_d;
    for (int j = 0; j < WinBytes; j++) begin
      win_q[j] <= win_d[j];
    end
  end

  always_comb begin
    phase_d   = phase_q;
    hdr_pos_d = hdr_pos_q;
    pay_idx_d = pay_idx_q;
    lane_d    = lane_q;
    pcrc_d    = pcrc_q;
    trl_d     = trl_q;
    for (int j = 0; j < WinBytes; j++) begin
      win_d[j] = win_q[j];
    end
    res_o = '0;

    if (step_i) begin
      case (phase_q)
        PH_HUNT: begin
          if (byte_i == cfg_i.sof_first) begin
            win_d[0] = byte_i;
            phase_d  = PH_SOF;
          end
        end
        PH_SOF: begin
          // a repeated first marker keeps waiting
          if (byte_i == cfg_i.sof_first) begin
            win_d[0] = byte_i;
          end else if (byte_i == cfg_i.sof_second) begin
            win_d[1]  = byte_i;
            hdr_pos_d = 4'd2;
            phase_d   = PH_HEADER;
          end else begin
            phase_d = PH_HUNT;
          end
        end
        PH_HEADER: begin
          for (int j = 0; j < WinBytes; j++) begin
            if (hdr_pos_q == 4'(j)) win_d[j] = byte_i;
          end
          hdr_pos_d = hdr_pos_q + 4'd1;
          if (hdr_pos_q == 4'(HdrBytes - 1)) begin
            if (hdr_bad) begin
              res_o.status = ST_HDR_ERR;
              // resync: earliest marker pair from position 1 moves to the front
              if (w[HdrBytes-1] == cfg_i.sof_first) begin
                win_d[0] = cfg_i.sof_first;
                phase_d  = PH_SOF;
              end else begin
                phase_d = PH_HUNT;
              end
              for (int k = HdrBytes - 2; k >= 1; k--) begin
                if (hit[k]) begin
                  for (int j = 0; j < WinBytes; j++) begin
                    if (j + k < HdrBytes) win_d[j] = w[j+k];
                  end
                  hdr_pos_d = 4'(HdrBytes - k);
                  phase_d   = PH_HEADER;
                end
              end
            end else begin
              pcrc_d    = '1;
              pay_idx_d = '0;
              lane_d    = '0;
              phase_d   = (len == 16'd0) ? PH_TRAILER : PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          pcrc_d              = crc32_byte(pcrc_q, byte_i);
          res_o.payload_valid = 1'b1;
          res_o.payload_byte  = byte_i;
          res_o.payload_index = pay_idx_q;
          pay_idx_d           = pay_idx_q + 16'd1;
          if (pay_idx_q + 16'd1 == len) phase_d = PH_TRAILER;
        end
        PH_TRAILER: begin
          lane_d = lane_q + 2'd1;
          case (lane_q)
            2'd0:    trl_d[7:0]   = byte_i;
            2'd1:    trl_d[15:8]  = byte_i;
            2'd2:    trl_d[23:16] = byte_i;
            default: begin
              if ({byte_i, trl_q} == ~pcrc_q) begin
                res_o.status         = ST_DONE;
                res_o.frame_version  = win_q[2];
                res_o.frame_command  = win_q[3];
                res_o.frame_sequence = {win_q[5], win_q[4]};
                res_o.frame_len      = len;
              end else begin
                res_o.status = ST_CRC_ERR;
              end
              pcrc_d  = '1;
              phase_d = PH_HUNT;
            end
          endcase
        end
        default: phase_d = PH_HUNT;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/frame_deframer_crc16_crc32.sv @@
// top level of the frame deframer: config registers, parser and output buffer
`timescale 1ns / 1ps
`default_nettype none

// Takes one received byte per input beat and gives exactly one result beat
// per input beat, in the cycle after it at the earliest. A beat is taken every
// cycle while the output side keeps up: the parser does its whole step
// (marker hunt, header crc-16 over the stored header bytes, resync search,
// per-byte crc-32) between the input port and the output register, and a
// one-beat skid register lets the next byte in while a result waits on a
// stalled output. in_stall_o rises only once both output slots hold results.
// Payload bytes are forwarded as they arrive and stay uncommitted until the
// frame's closing status: frame complete commits them, payload crc error
// means they must be dropped. Header fields are given only with frame
// complete. Registers sit at byte addresses 0 (first marker), 4 (second
// marker) and 8 (largest payload length); change them only while idle.

module frame_deframer_crc16_crc32 import fdc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // config port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // byte input
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  // result output
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       status_o,
  output logic             payload_valid_o,
  output logic [7:0]       payload_byte_o,
  output logic [15:0]      payload_index_o,
  output logic [7:0]       frame_version_o,
  output logic [7:0]       frame_command_o,
  output logic [15:0]      frame_sequence_o,
  output logic [15:0]      frame_len_o
);

  cfg_t    cfg_q;
  result_t res;
  result_t out_q, skid_q;
  logic    out_vld_q, skid_vld_q;
  logic    in_acc, out_acc, cfg_wr;

  // config registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sof_first   <= SOF_FIRST_RST;
      cfg_q.sof_second  <= SOF_SECOND_RST;
      cfg_q.max_payload <= MAX_PAYLOAD_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_SOF_FIRST:   cfg_q.sof_first   <= pwdata[7:0];
        REG_SOF_SECOND:  cfg_q.sof_second  <= pwdata[7:0];
        REG_MAX_PAYLOAD: cfg_q.max_payload <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_SOF_FIRST:   prdata = {24'h0, cfg_q.sof_first};
      REG_SOF_SECOND:  prdata = {24'h0, cfg_q.sof_second};
      REG_MAX_PAYLOAD: prdata = {16'h0, cfg_q.max_payload};
      default:         prdata = '0;
    endcase
  end

  // input side only stalls once the skid slot is taken
  assign in_stall_o = skid_vld_q;
  assign in_acc     = in_valid_i && !skid_vld_q;
  assign out_acc    = out_vld_q && !out_stall_i;

  fdc_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (in_acc),
    .byte_i (data_byte_i),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  // output register plus skid slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (!out_vld_q || out_acc) begin
        if (skid_vld_q) begin
          out_vld_q  <= 1'b1;
          skid_vld_q <= 1'b0;
        end else begin
          out_vld_q <= in_acc;
        end
      end else if (in_acc) begin
        skid_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_vld_q || out_acc) begin
      if (skid_vld_q) begin
        out_q <= skid_q;
      end else if (in_acc) begin
        out_q <= res;
      end
    end else if (in_acc) begin
      skid_q <= res;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign status_o         = out_q.status;
  assign payload_valid_o  = out_q.payload_valid;
  assign payload_byte_o   = out_q.payload_byte;
  assign payload_index_o  = out_q.payload_index;
  assign frame_version_o  = out_q.frame_version;
  assign frame_command_o  = out_q.frame_command;
  assign frame_sequence_o = out_q.frame_sequence;
  assign frame_len_o      = out_q.frame_len;

  // skid slot is only ever filled behind a held output beat
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid slot full while output register empty");

  // a forwarded payload byte never carries a frame status
  a_payload_no_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && payload_valid_o) |-> (status_o == ST_NONE))
    else $error("payload beat carries a status");

  // header fields only come with frame complete
  a_fields_with_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != ST_DONE)) |->
      (frame_len_o == 16'd0 && frame_sequence_o == 16'd0))
    else $error("frame fields set without frame complete");

endmodule

`default_nettype wire

@@ tb/fdc_tb_pkg.sv @@
// crc helpers and the scoreboard class that predicts and checks deframer results
`timescale 1ns / 1ps

package fdc_tb_pkg;
  import fdc_pkg::*;

  localparam int HDR_LEN   = 10;
  localparam int MAX_SHOWN = 10;

  // crc-16/ccitt-false, msb first
  function automatic logic [15:0] crc16_ccitt_byte(logic [15:0] c, logic [7:0] b);
    int k;
    c ^= {b, 8'h00};
    for (k = 0; k < 8; k++) c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
    return c;
  endfunction

  // reflected crc-32, lsb first
  function automatic logic [31:0] crc32_refl_byte(logic [31:0] c, logic [7:0] b);
    int k;
    c ^= {24'h0, b};
    for (k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
    return c;
  endfunction

  class deframe_checker;
    cfg_t        cfg;
    logic [7:0]  hdr [HDR_LEN];
    logic [16:0] frame_pos;
    logic [31:0] run_crc;
    logic [31:0] trailer;
    result_t     due_results [$];
    int unsigned beats, results_seen, mismatches;
    int unsigned frames_done, hdr_errors, crc_errors, forwarded;

    function new();
      int i;
      cfg.sof_first   = SOF_FIRST_RST;
      cfg.sof_second  = SOF_SECOND_RST;
      cfg.max_payload = MAX_PAYLOAD_RST;
      for (i = 0; i < HDR_LEN; i++) hdr[i] = '0;
      frame_pos = '0;
      run_crc   = '1;
      trailer   = '0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        REG_SOF_FIRST:   cfg.sof_first   = value[7:0];
        REG_SOF_SECOND:  cfg.sof_second  = value[7:0];
        REG_MAX_PAYLOAD: cfg.max_payload = value[15:0];
        default: ;
      endcase
    endfunction

    function int unsigned due_count();
      return due_results.size();
    endfunction

    // one accepted input byte gives exactly one expected result
    function void parse_byte(logic [7:0] b);
      result_t     r;
      logic [15:0] len, hcrc;
      logic [16:0] offs;
      logic [1:0]  lane;
      int          i, j;
      bit          found;
      r = '0;
      beats++;
      len = {hdr[7], hdr[6]};
      if (frame_pos == 0) begin
        if (b == cfg.sof_first) begin
          hdr[0] = b;
          frame_pos = 1;
        end
      end else if (frame_pos == 1) begin
        if (b == cfg.sof_first) begin
          hdr[0] = b;
        end else if (b == cfg.sof_second) begin
          hdr[1] = b;
          frame_pos = 2;
        end else begin
          frame_pos = 0;
        end
      end else if (frame_pos < HDR_LEN) begin
        hdr[frame_pos[3:0]] = b;
        frame_pos++;
        if (frame_pos == HDR_LEN) begin
          len  = {hdr[7], hdr[6]};
          hcrc = 16'hFFFF;
          for (i = 2; i < 8; i++) hcrc = crc16_ccitt_byte(hcrc, hdr[i]);
          if (len > cfg.max_payload || {hdr[9], hdr[8]} != hcrc) begin
            r.status = ST_HDR_ERR;
            // look for a fresh marker pair inside the rejected header
            found = 0;
            for (i = 1; i < HDR_LEN - 1 && !found; i++) begin
              if (hdr[i] == cfg.sof_first && hdr[i + 1] == cfg.sof_second) begin
                for (j = 0; j < HDR_LEN - i; j++) hdr[j] = hdr[i + j];
                frame_pos = HDR_LEN - i;
                found = 1;
              end
            end
            if (!found) begin
              if (hdr[HDR_LEN - 1] == cfg.sof_first) begin
                hdr[0] = cfg.sof_first;
                frame_pos = 1;
              end else begin
                frame_pos = 0;
              end
            end
          end else begin
            run_crc = '1;
          end
        end
      end else begin
        offs = frame_pos - HDR_LEN;
        if (offs < {1'b0, len}) begin
          run_crc = crc32_refl_byte(run_crc, b);
          r.payload_valid = 1'b1;
          r.payload_byte  = b;
          r.payload_index = offs[15:0];
          frame_pos++;
        end else begin
          lane = offs[1:0] - len[1:0];
          if (lane == 0) trailer = {24'h0, b};
          else trailer[lane * 8 +: 8] = b;
          if (lane == 3) begin
            if (trailer == ~run_crc) begin
              r.status         = ST_DONE;
              r.frame_version  = hdr[2];
              r.frame_command  = hdr[3];
              r.frame_sequence = {hdr[5], hdr[4]};
              r.frame_len      = len;
            end else begin
              r.status = ST_CRC_ERR;
            end
            frame_pos = 0;
            run_crc   = '1;
          end else begin
            frame_pos++;
          end
        end
      end
      case (r.status)
        ST_DONE:    frames_done++;
        ST_HDR_ERR: hdr_errors++;
        ST_CRC_ERR: crc_errors++;
        default: ;
      endcase
      if (r.payload_valid) forwarded++;
      due_results.push_back(r);
    endfunction

    function string show(result_t r);
      return $sformatf("status %0d pv %0b byte %02h idx %0d ver %02h cmd %02h seq %04h len %0d",
                       r.status, r.payload_valid, r.payload_byte, r.payload_index,
                       r.frame_version, r.frame_command, r.frame_sequence, r.frame_len);
    endfunction

    function void compare_result(result_t got);
      result_t want;
      results_seen++;
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("result beat %0d arrived with nothing expected: %s", results_seen, show(got));
        return;
      end
      want = due_results.pop_front();
      if (got.status !== want.status || got.payload_valid !== want.payload_valid ||
          got.payload_byte !== want.payload_byte ||
          got.payload_index !== want.payload_index ||
          got.frame_version !== want.frame_version ||
          got.frame_command !== want.frame_command ||
          got.frame_sequence !== want.frame_sequence ||
          got.frame_len !== want.frame_len) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("mismatch on result beat %0d\n  expected %s\n  actual   %s",
                   results_seen, show(want), show(got));
      end
    endfunction
  endclass

endpackage

@@ tb/testbench.sv @@
// top-level testbench for the frame deframer with crc-16 header and crc-32 payload checks
`timescale 1ns / 1ps

module testbench;
  import fdc_pkg::*;
  import fdc_tb_pkg::*;

  localparam int QUIET_LIMIT = 3000;  // cycles with no beat on either side
  localparam int SETTLE      = 6;     // latency margin before register writes and at the end
  localparam int LONG_HOLD   = 90;    // receiver hold-off that fills the output slots

  typedef enum int {
    FR_GOOD,
    FR_BAD_TRAILER,
    FR_BAD_HDR,
    FR_OVERSIZE,
    FR_TRUNCATED,
    FR_OPEN,
    FR_NOISE
  } frame_kind_e;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel, penable, pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  data_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [1:0]  status_o;
  logic        payload_valid_o;
  logic [7:0]  payload_byte_o;
  logic [15:0] payload_index_o;
  logic [7:0]  frame_version_o;
  logic [7:0]  frame_command_o;
  logic [15:0] frame_sequence_o;
  logic [15:0] frame_len_o;

  deframe_checker sb;
  int unsigned    tx_idle_pct, rx_idle_pct;
  int unsigned    hold_req, hold_left;
  int unsigned    counted_beats;
  int unsigned    quiet_cycles;

  frame_deframer_crc16_crc32 u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .data_byte_i      (data_byte_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .payload_valid_o  (payload_valid_o),
    .payload_byte_o   (payload_byte_o),
    .payload_index_o  (payload_index_o),
    .frame_version_o  (frame_version_o),
    .frame_command_o  (frame_command_o),
    .frame_sequence_o (frame_sequence_o),
    .frame_len_o      (frame_len_o)
  );

  always #6 clk_i = ~clk_i;

  // result side: values read just after the edge are the ones the edge saw,
  // so a beat counts when valid was high and our stall was low
  always @(posedge clk_i) begin
    result_t got;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got.status         = status_e'(status_o);
        got.payload_valid  = payload_valid_o;
        got.payload_byte   = payload_byte_o;
        got.payload_index  = payload_index_o;
        got.frame_version  = frame_version_o;
        got.frame_command  = frame_command_o;
        got.frame_sequence = frame_sequence_o;
        got.frame_len      = frame_len_o;
        sb.compare_result(got);
      end
      // a long hold-off is counted down here, independent of the sender
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  // watchdog: a run that stops moving beats is a failure
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("no beat moved for %0d cycles, %0d results outstanding",
                 quiet_cycles, sb.due_count());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // setup cycle, then access cycle; the register takes the value on the
  // edge where pready is seen high during access
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'h0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(idx, {16'h0, value});
  endtask

  task automatic set_config(input logic [7:0] first, input logic [7:0] second,
                            input logic [15:0] max_len);
    write_reg(REG_SOF_FIRST, {8'h0, first});
    write_reg(REG_SOF_SECOND, {8'h0, second});
    write_reg(REG_MAX_PAYLOAD, max_len);
  endtask

  // offer one byte, with a random gap first; valid stays high afterwards so
  // back-to-back bytes need no second assignment in the same step
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = 0;
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    sb.parse_byte(b);
  endtask

  // stop offering and wait until every expected result has been taken
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.due_count() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // builds one byte sequence of the given kind and sends it;
  // plant puts a marker pair at that header position (2..8), or a lone
  // first marker in the last header byte (9), to exercise resync
  task automatic send_frame(input frame_kind_e kind, input logic [7:0] ver,
                            input logic [7:0] cmd, input logic [15:0] seq,
                            input logic [15:0] len, input int plant, input bit edge_fill);
    logic [7:0]  hb [HDR_LEN];
    logic [7:0]  fr [$];
    logic [15:0] hcrc;
    logic [31:0] pcrc, trail;
    logic [7:0]  pb;
    int unsigned lead, cut;
    int          k;
    if (kind == FR_NOISE) begin
      // mostly random bytes, with first markers sprinkled in
      repeat ($urandom_range(8, 1))
        fr.push_back(($urandom_range(3) == 0) ? sb.cfg.sof_first : 8'($urandom));
    end else begin
      // repeated first markers keep the hunt waiting for the second one
      lead = edge_fill ? 1 : ((kind == FR_GOOD && $urandom_range(4) == 0) ? $urandom_range(2, 1) : 0);
      repeat (lead) fr.push_back(sb.cfg.sof_first);
      hb[0] = sb.cfg.sof_first;
      hb[1] = sb.cfg.sof_second;
      hb[2] = ver;
      hb[3] = cmd;
      hb[4] = seq[7:0];
      hb[5] = seq[15:8];
      hb[6] = len[7:0];
      hb[7] = len[15:8];
      hcrc = 16'hFFFF;
      for (k = 2; k < 8; k++) hcrc = crc16_ccitt_byte(hcrc, hb[k]);
      if (kind == FR_BAD_HDR) hcrc ^= 16'($urandom_range(65535, 1));
      hb[8] = hcrc[7:0];
      hb[9] = hcrc[15:8];
      if (kind == FR_BAD_HDR && plant == 9) begin
        hb[9] = sb.cfg.sof_first;
      end else if (kind == FR_BAD_HDR && plant >= 2) begin
        hb[plant]     = sb.cfg.sof_first;
        hb[plant + 1] = sb.cfg.sof_second;
      end
      for (k = 0; k < HDR_LEN; k++) fr.push_back(hb[k]);
      if (kind != FR_BAD_HDR && kind != FR_OVERSIZE) begin
        pcrc = '1;
        for (k = 0; k < len; k++) begin
          pb = edge_fill ? (k[0] ? 8'h00 : 8'hFF) : 8'($urandom);
          pcrc = crc32_refl_byte(pcrc, pb);
          fr.push_back(pb);
        end
        trail = ~pcrc;
        if (kind == FR_BAD_TRAILER) trail ^= 32'h1 << $urandom_range(31);
        for (k = 0; k < 4; k++) fr.push_back(trail[8 * k +: 8]);
        if (kind == FR_TRUNCATED) begin
          cut = $urandom_range(fr.size() - 1, 1);
          repeat (cut) void'(fr.pop_back());
        end
        // a frame left open across a register change keeps its length
        if (kind == FR_OPEN)
          while (fr.size() > lead + HDR_LEN + 5) void'(fr.pop_back());
      end
    end
    for (k = 0; k < fr.size(); k++) send_byte(fr[k]);
    if (kind != FR_NOISE) counted_beats += fr.size();
  endtask

  task automatic send_random_frame();
    frame_kind_e kind;
    int unsigned pick, cap;
    logic [15:0] len, seq;
    logic [7:0]  ver, cmd;
    int          plant;
    pick = $urandom_range(99);
    if (pick < 50)      kind = FR_GOOD;
    else if (pick < 60) kind = FR_BAD_TRAILER;
    else if (pick < 70) kind = FR_BAD_HDR;
    else if (pick < 77) kind = FR_OVERSIZE;
    else if (pick < 87) kind = FR_TRUNCATED;
    else                kind = FR_NOISE;
    if (kind == FR_OVERSIZE && sb.cfg.max_payload == 16'hFFFF) kind = FR_BAD_HDR;
    // short payloads mostly, an occasional longer one
    cap = (sb.cfg.max_payload < 40) ? sb.cfg.max_payload : 40;
    if ($urandom_range(19) == 0) cap = (sb.cfg.max_payload < 300) ? sb.cfg.max_payload : 300;
    len = 16'($urandom_range(cap, 0));
    if (kind == FR_OVERSIZE) len = 16'($urandom_range(65535, sb.cfg.max_payload + 1));
    plant = $urandom_range(1) ? 0 : $urandom_range(9, 2);
    ver = 8'($urandom);
    cmd = 8'($urandom);
    seq = 16'($urandom);
    send_frame(kind, ver, cmd, seq, len, plant, 1'b0);
  endtask

  task automatic random_phase(input int unsigned beats);
    int unsigned start;
    start = counted_beats;
    while (counted_beats - start < beats) send_random_frame();
  endtask

  initial begin
    sb          = new();
    rst_ni      = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    in_valid_i  = 1'b0;
    data_byte_i = '0;
    out_stall_i = 1'b0;
    hold_req    = 0;
    hold_left   = 0;
    quiet_cycles  = 0;
    counted_beats = 0;
    // sender sparse idling, receiver stalls often
    tx_idle_pct = 28;
    rx_idle_pct = 69;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_config(SOF_FIRST_RST, SOF_SECOND_RST, MAX_PAYLOAD_RST);
    // directed: good frame with extreme header and payload bytes after a
    // doubled first marker, then a bad header carrying a marker pair inside
    send_frame(FR_GOOD, 8'hFF, 8'h00, 16'hFF00, 16'd2, 0, 1'b1);
    send_frame(FR_BAD_HDR, 8'h11, 8'h22, 16'h3344, 16'h0055, 4, 1'b0);
    random_phase(330);
    send_frame(FR_OPEN, 8'h01, 8'h02, 16'h0003, 16'd20, 0, 1'b0);
    drain();

    // roles swapped: sender idles often, receiver rarely
    tx_idle_pct = 69;
    rx_idle_pct = 28;
    set_config(8'h00, 8'hFF, 16'd0);
    random_phase(200);
    drain();
    set_config(8'hFF, 8'h00, 16'hFFFF);
    random_phase(300);
    drain();

    // no random idling from here on
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    // equal markers: no frame may ever start
    set_config(8'h3C, 8'h3C, 16'd7);
    random_phase(80);
    drain();
    set_config(SOF_FIRST_RST, SOF_SECOND_RST, 16'd300);
    // receiver holds off while bytes keep coming, so the input backs up
    hold_req = LONG_HOLD;
    random_phase(220);
    // sender pauses until all results are back
    drain();
    random_phase(200);
    drain();

    $display("covered %0d byte beats over five register settings: default, 00/FF and FF/00 markers, equal markers, payload limits 0 to 65535",
             sb.beats);
    $display("seen %0d frames complete, %0d header errors, %0d payload crc errors, %0d payload bytes, %0d mismatches",
             sb.frames_done, sb.hdr_errors, sb.crc_errors, sb.forwarded, sb.mismatches);
    if (sb.due_count() != 0) $display("%0d expected results never arrived", sb.due_count());
    if (sb.mismatches == 0 && sb.due_count() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/fdc_pkg.sv
rtl/core/fdc_parser.sv
rtl/core/frame_deframer_crc16_crc32.sv
tb/fdc_tb_pkg.sv
tb/testbench.sv
